[design/ibf_pkg.sv]
package ibf_pkg;

    // field widths
    localparam int RAW_W      = 16;
    localparam int TIME_W     = 32;
    localparam int FILT_W     = 21;
    localparam int HEAD_W     = 32;
    localparam int LOG2_W     = 4;
    localparam int AGAIN_W    = 16;
    localparam int ALPHA_W    = 17;
    localparam int GGAIN_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // fixed point
    localparam int FRAC_W       = 8;   // bias fraction bits
    localparam int SCALE_SH     = 16;  // Q.16 scaling / filter shift
    localparam int GYRO_SH      = 24;  // heading product shift
    localparam int GYRO_MOD_W   = GYRO_SH + HEAD_W;  // product bits that reach the heading
    localparam int GYRO_SLICE_W = 16;  // operand slice of the gyro multiplier

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

    localparam logic signed [FILT_W-1:0] FILT_MAX = 21'sh0FFFFF;
    localparam logic signed [FILT_W-1:0] FILT_MIN = 21'sh100000;

    // register reset values
    localparam logic [LOG2_W-1:0]  RST_CALIB_LOG2   = 4'd9;
    localparam logic [AGAIN_W-1:0] RST_ACCEL_GAIN   = 16'd1024;
    localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA = 17'd13107;
    localparam logic [GGAIN_W-1:0] RST_GYRO_GAIN    = 24'd5968511;

    typedef logic signed [RAW_W-1:0]  t_raw;
    typedef logic signed [FILT_W-1:0] t_filt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CALIB_LOG2,
        CFG_ACCEL_GAIN,
        CFG_FILTER_ALPHA,
        CFG_GYRO_GAIN
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CAL,
        ST_MEAS,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_PREP,
        PH_MUL1,
        PH_MUL2,
        PH_MUL3,
        PH_MUL4,
        PH_COMMIT
    } t_phase;

    typedef struct packed {
        logic   run;
        t_phase phase;
        logic   clear;
    } t_lane_ctl;

    typedef struct packed {
        logic              operation;
        t_raw              accel_x_raw;
        t_raw              accel_y_raw;
        t_raw              accel_z_raw;
        t_raw              gyro_z_raw;
        logic [TIME_W-1:0] time_ms;
    } t_item;

endpackage

[design/ibf_in_if.sv]
interface ibf_in_if import ibf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    t_raw              accel_x_raw;
    t_raw              accel_y_raw;
    t_raw              accel_z_raw;
    t_raw              gyro_z_raw;
    logic [TIME_W-1:0] time_ms;

    modport source (
        output valid, operation, accel_x_raw, accel_y_raw, accel_z_raw, gyro_z_raw, time_ms,
        input  ready
    );
    modport sink (
        input  valid, operation, accel_x_raw, accel_y_raw, accel_z_raw, gyro_z_raw, time_ms,
        output ready
    );
endinterface

[design/ibf_out_if.sv]
interface ibf_out_if import ibf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     is_calibrated;
    t_filt                    accel_x_filt;
    t_filt                    accel_y_filt;
    t_filt                    accel_z_filt;
    logic signed [HEAD_W-1:0] heading_angle;

    modport source (
        output valid, is_calibrated, accel_x_filt, accel_y_filt, accel_z_filt, heading_angle,
        input  ready
    );
    modport sink (
        input  valid, is_calibrated, accel_x_filt, accel_y_filt, accel_z_filt, heading_angle,
        output ready
    );
endinterface

[design/ibf_cfg_if.sv]
interface ibf_cfg_if import ibf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/ibf_accel_lane.sv]
module ibf_accel_lane
    import ibf_pkg::*;
#(
    parameter int BIAS_W = 37
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  t_raw                     i_raw,
    input  logic signed [BIAS_W-1:0] i_bias,
    input  logic [AGAIN_W-1:0]       i_gain,
    input  logic [ALPHA_W-1:0]       i_alpha,
    input  logic [ALPHA_W-1:0]       i_beta,
    output t_filt                    o_filt
);

    localparam int D_W    = BIAS_W + 1;
    localparam int MB_W   = ALPHA_W + 1;
    localparam int PROD_W = D_W + MB_W;
    localparam int FW_W   = PROD_W - SCALE_SH;

    logic signed [RAW_W+FRAC_W-1:0] raw_sh;
    logic signed [D_W-1:0]          d_next;
    logic signed [D_W-1:0]          mul_a;
    logic signed [MB_W-1:0]         mul_b;
    logic signed [PROD_W-1:0]       prod;
    logic signed [FW_W-1:0]         f_wide;
    t_filt                          f_sat;

    logic signed [D_W-1:0]    r_d;
    logic signed [D_W-1:0]    r_a;
    logic signed [PROD_W-1:0] r_acc;
    t_filt                    r_filt;

    always_comb begin
        raw_sh = {i_raw, {FRAC_W{1'b0}}};
        d_next = D_W'(raw_sh) - D_W'(i_bias);
    end

    // one shared signed multiplier: gain, then alpha, then (1 - alpha)
    always_comb begin
        unique case (i_ctl.phase)
            PH_MUL1: begin
                mul_a = r_d;
                mul_b = $signed({{(MB_W-AGAIN_W){1'b0}}, i_gain});
            end
            PH_MUL2: begin
                mul_a = r_a;
                mul_b = $signed({1'b0, i_alpha});
            end
            PH_MUL3: begin
                mul_a = D_W'(r_filt);
                mul_b = $signed({1'b0, i_beta});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_comb begin
        f_wide = r_acc[PROD_W-1:SCALE_SH];
        if (f_wide > FW_W'(FILT_MAX)) begin
            f_sat = FILT_MAX;
        end else if (f_wide < FW_W'(FILT_MIN)) begin
            f_sat = FILT_MIN;
        end else begin
            f_sat = f_wide[FILT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.run) begin
            unique case (i_ctl.phase)
                PH_PREP: r_d   <= d_next;
                PH_MUL1: r_a   <= prod[D_W+SCALE_SH-1:SCALE_SH];
                PH_MUL2: r_acc <= prod;
                PH_MUL3: r_acc <= r_acc + prod;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= '0;
        end else if (i_ctl.run && i_ctl.phase == PH_COMMIT) begin
            r_filt <= f_sat;
        end
    end

    assign o_filt = r_filt;

endmodule

[design/ibf_gyro_lane.sv]
module ibf_gyro_lane
    import ibf_pkg::*;
#(
    parameter int BIAS_W = 37
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  t_raw                     i_raw,
    input  logic signed [BIAS_W-1:0] i_bias,
    input  logic [GGAIN_W-1:0]       i_gain,
    input  logic [TIME_W-1:0]        i_time,
    output logic signed [HEAD_W-1:0] o_heading
);

    localparam int D_W = BIAS_W + 1;

    logic signed [RAW_W+FRAC_W-1:0] raw_sh;
    logic signed [D_W-1:0]          d_next;
    logic [GYRO_MOD_W-1:0]          mul_a;
    logic [GYRO_SLICE_W-1:0]        mul_b;
    logic [GYRO_MOD_W-1:0]          prod;

    logic [GYRO_MOD_W-1:0] r_gd;
    logic [TIME_W-1:0]     r_dt;
    logic [GYRO_MOD_W-1:0] r_p1;
    logic [GYRO_MOD_W-1:0] r_p2;
    logic [HEAD_W-1:0]     r_heading;
    logic [TIME_W-1:0]     r_last_time;

    always_comb begin
        raw_sh = {i_raw, {FRAC_W{1'b0}}};
        d_next = D_W'(raw_sh) - D_W'(i_bias);
    end

    // everything is modulo 2^56: only product bits 55..24 reach the heading
    always_comb begin
        unique case (i_ctl.phase)
            PH_MUL1: begin
                mul_a = r_gd;
                mul_b = i_gain[GYRO_SLICE_W-1:0];
            end
            PH_MUL2: begin
                mul_a = r_gd;
                mul_b = GYRO_SLICE_W'(i_gain[GGAIN_W-1:GYRO_SLICE_W]);
            end
            PH_MUL3: begin
                mul_a = r_p1;
                mul_b = r_dt[GYRO_SLICE_W-1:0];
            end
            PH_MUL4: begin
                mul_a = r_p1;
                mul_b = r_dt[TIME_W-1:GYRO_SLICE_W];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.run) begin
            unique case (i_ctl.phase)
                PH_PREP: begin
                    r_gd <= GYRO_MOD_W'(d_next);
                    r_dt <= i_time - r_last_time;
                end
                PH_MUL1: r_p1 <= prod;
                PH_MUL2: r_p1 <= r_p1 + (prod << GYRO_SLICE_W);
                PH_MUL3: r_p2 <= prod;
                PH_MUL4: r_p2 <= r_p2 + (prod << GYRO_SLICE_W);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading   <= '0;
            r_last_time <= '0;
        end else if (i_ctl.clear) begin
            r_heading   <= '0;
            r_last_time <= i_time;
        end else if (i_ctl.run && i_ctl.phase == PH_COMMIT) begin
            r_heading   <= r_heading + r_p2[GYRO_MOD_W-1:GYRO_SH];
            r_last_time <= i_time;
        end
    end

    assign o_heading = r_heading;

endmodule

[design/imu_bias_filter_heading_top.sv]
// IMU bias calibration, accelerometer smoothing and gyro heading integration.
// Items come in on i_in: operation 0 is a calibration sample, which is summed
// per axis; once 2^calib_log2 of them have arrived (calib_log2 is clamped to
// MAX_CAL_LOG2) the sums become Q.8 biases, the block reports calibrated, the
// heading is cleared and the timestamp is latched. Operation 1 is a
// measurement: bias removed, scaled, the three accel axes run through a
// saturating Q12.8 exponential filter and gyro rate times elapsed ms is added
// to a binary-angle heading that wraps. A measurement before calibration
// changes nothing. Every transaction on i_in gives exactly one transaction on
// o_out carrying the state after that item. Four lanes work side by side (one
// per accel axis, one for the gyro), each around its own multiplier, and the
// output stage merges what they hold into one result. One item is in work at a
// time: a calibrated measurement passes through the lane phases and a
// calibration sample through the accumulator step before the output load,
// while a measurement before calibration goes straight to that load. The
// next item is taken only once the result is in the output register.
// The measurement time is set by the gyro lane: operand set-up, four partial
// products of rate x gain x dt through its single 56x16 multiplier and the
// heading update, then the output load. The output register decouples the
// two sides: a new transaction is accepted while an earlier result still
// waits on o_out.ready.
// Configuration writes on i_cfg are always accepted and must only be made
// while the block is idle.
module imu_bias_filter_heading_top
    import ibf_pkg::*;
#(
    parameter int MAX_CAL_LOG2 = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ibf_in_if.sink          i_in,
    ibf_out_if.source       o_out,
    ibf_cfg_if.sink         i_cfg
);

    localparam int CNT_W  = MAX_CAL_LOG2 + 1;
    localparam int SUM_W  = RAW_W + MAX_CAL_LOG2 + 1;
    localparam int BIAS_W = SUM_W + FRAC_W;
    localparam int N_AXES = 4;   // accel x, y, z, gyro z
    localparam int GYRO   = 3;

    // ---------------- configuration registers ----------------
    logic [LOG2_W-1:0]  r_calib_log2;
    logic [AGAIN_W-1:0] r_accel_gain;
    logic [ALPHA_W-1:0] r_filter_alpha;
    logic [GGAIN_W-1:0] r_gyro_gain;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_log2   <= RST_CALIB_LOG2;
            r_accel_gain   <= RST_ACCEL_GAIN;
            r_filter_alpha <= RST_FILTER_ALPHA;
            r_gyro_gain    <= RST_GYRO_GAIN;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_CALIB_LOG2:   r_calib_log2   <= i_cfg.data[LOG2_W-1:0];
                CFG_ACCEL_GAIN:   r_accel_gain   <= i_cfg.data[AGAIN_W-1:0];
                CFG_FILTER_ALPHA: r_filter_alpha <= i_cfg.data[ALPHA_W-1:0];
                CFG_GYRO_GAIN:    r_gyro_gain    <= i_cfg.data[GGAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // alpha above one is taken as one; beta is the weight of the old value
    logic [ALPHA_W-1:0] alpha_eff;
    logic [ALPHA_W-1:0] beta;

    always_comb begin
        alpha_eff = (r_filter_alpha > ALPHA_ONE) ? ALPHA_ONE : r_filter_alpha;
        beta      = ALPHA_ONE - alpha_eff;
    end

    // ---------------- sequencer ----------------
    t_state    r_state;
    t_state    n_state;
    t_phase    r_phase;
    t_phase    n_phase;
    t_lane_ctl lane_ctl;
    logic      in_take;
    logic      cal_step;
    logic      out_load;
    logic      cal_hit;
    logic      r_cal_done;
    logic      r_out_valid;

    assign in_take = i_in.valid && i_in.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (!i_in.operation) begin
                        n_state = ST_CAL;
                    end else if (r_cal_done) begin
                        n_state = ST_MEAS;
                    end else begin
                        n_state = ST_DONE;    // uncalibrated measurement: nothing moves
                    end
                end
            end
            ST_CAL:  n_state = ST_DONE;
            ST_MEAS: begin
                if (r_phase == PH_COMMIT) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_phase)
            PH_PREP: n_phase = PH_MUL1;
            PH_MUL1: n_phase = PH_MUL2;
            PH_MUL2: n_phase = PH_MUL3;
            PH_MUL3: n_phase = PH_MUL4;
            PH_MUL4: n_phase = PH_COMMIT;
            default: n_phase = PH_PREP;
        endcase
    end

    always_comb begin
        i_in.ready     = (r_state == ST_IDLE);
        cal_step       = (r_state == ST_CAL);
        out_load       = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);
        lane_ctl.run   = (r_state == ST_MEAS);
        lane_ctl.phase = r_phase;
        lane_ctl.clear = cal_step && cal_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_PREP;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MEAS) begin
                r_phase <= n_phase;
            end else begin
                r_phase <= PH_PREP;
            end
        end
    end

    // ---------------- item register ----------------
    t_item r_item;
    t_raw  raw [N_AXES];

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.operation   <= i_in.operation;
            r_item.accel_x_raw <= i_in.accel_x_raw;
            r_item.accel_y_raw <= i_in.accel_y_raw;
            r_item.accel_z_raw <= i_in.accel_z_raw;
            r_item.gyro_z_raw  <= i_in.gyro_z_raw;
            r_item.time_ms     <= i_in.time_ms;
        end
    end

    always_comb begin
        raw[0]    = r_item.accel_x_raw;
        raw[1]    = r_item.accel_y_raw;
        raw[2]    = r_item.accel_z_raw;
        raw[GYRO] = r_item.gyro_z_raw;
    end

    // ---------------- calibration accumulators ----------------
    logic [CNT_W-1:0]         r_count;
    logic signed [SUM_W-1:0]  r_sum  [N_AXES];
    logic signed [BIAS_W-1:0] r_bias [N_AXES];

    logic [LOG2_W-1:0]        k;
    logic [CNT_W-1:0]         count_new;
    logic signed [SUM_W-1:0]  sum_new  [N_AXES];
    logic signed [BIAS_W-1:0] sum_sh   [N_AXES];
    logic signed [BIAS_W-1:0] bias_new [N_AXES];

    // bias = floor(sum * 2^8 / 2^k): an arithmetic shift, the count is a power of two
    always_comb begin
        k         = (32'(r_calib_log2) > MAX_CAL_LOG2) ? LOG2_W'(MAX_CAL_LOG2) : r_calib_log2;
        count_new = r_count + CNT_W'(1);
        cal_hit   = (count_new >= (CNT_W'(1) << k));   // also catches a count lowered mid-run
        for (int i = 0; i < N_AXES; i++) begin
            sum_new[i]  = r_sum[i] + SUM_W'(raw[i]);
            sum_sh[i]   = {sum_new[i], {FRAC_W{1'b0}}};
            bias_new[i] = sum_sh[i] >>> k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_cal_done <= 1'b0;
            for (int i = 0; i < N_AXES; i++) begin
                r_sum[i]  <= '0;
                r_bias[i] <= '0;
            end
        end else if (cal_step) begin
            if (cal_hit) begin
                r_count    <= '0;
                r_cal_done <= 1'b1;
                for (int i = 0; i < N_AXES; i++) begin
                    r_sum[i]  <= '0;
                    r_bias[i] <= bias_new[i];
                end
            end else begin
                r_count <= count_new;
                for (int i = 0; i < N_AXES; i++) begin
                    r_sum[i] <= sum_new[i];
                end
            end
        end
    end

    // ---------------- lanes ----------------
    t_filt                    filt [3];
    logic signed [HEAD_W-1:0] heading;

    for (genvar g = 0; g < 3; g++) begin : g_accel
        ibf_accel_lane #(
            .BIAS_W (BIAS_W)
        ) u_accel (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_raw   (raw[g]),
            .i_bias  (r_bias[g]),
            .i_gain  (r_accel_gain),
            .i_alpha (alpha_eff),
            .i_beta  (beta),
            .o_filt  (filt[g])
        );
    end

    ibf_gyro_lane #(
        .BIAS_W (BIAS_W)
    ) u_gyro (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (lane_ctl),
        .i_raw     (raw[GYRO]),
        .i_bias    (r_bias[GYRO]),
        .i_gain    (r_gyro_gain),
        .i_time    (r_item.time_ms),
        .o_heading (heading)
    );

    // ---------------- merge into the output register ----------------
    logic                     r_out_cal;
    t_filt                    r_out_x;
    t_filt                    r_out_y;
    t_filt                    r_out_z;
    logic signed [HEAD_W-1:0] r_out_heading;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_cal     <= r_cal_done;
            r_out_x       <= filt[0];
            r_out_y       <= filt[1];
            r_out_z       <= filt[2];
            r_out_heading <= heading;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.is_calibrated = r_out_cal;
    assign o_out.accel_x_filt  = r_out_x;
    assign o_out.accel_y_filt  = r_out_y;
    assign o_out.accel_z_filt  = r_out_z;
    assign o_out.heading_angle = r_out_heading;

endmodule

[design/ibf_chk.sv]
module ibf_chk
    import ibf_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic                     i_is_calibrated,
    input t_filt                    i_accel_x_filt,
    input t_filt                    i_accel_y_filt,
    input t_filt                    i_accel_z_filt,
    input logic signed [HEAD_W-1:0] i_heading_angle
);

    // a stalled result keeps its valid and its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_heading_angle)
            && $stable(i_accel_x_filt) && $stable(i_accel_y_filt)
            && $stable(i_accel_z_filt) && $stable(i_is_calibrated))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in work");

    // calibrated status never drops between back-to-back results
    a_cal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && $past(i_out_valid) |-> !$fell(i_is_calibrated))
        else $error("calibrated status dropped");

    // before calibration nothing has been filtered or integrated
    a_uncal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_is_calibrated |-> i_heading_angle == '0
            && i_accel_x_filt == '0 && i_accel_y_filt == '0 && i_accel_z_filt == '0)
        else $error("state moved before calibration");

endmodule

bind imu_bias_filter_heading_top ibf_chk u_ibf_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_is_calibrated (o_out.is_calibrated),
    .i_accel_x_filt  (o_out.accel_x_filt),
    .i_accel_y_filt  (o_out.accel_y_filt),
    .i_accel_z_filt  (o_out.accel_z_filt),
    .i_heading_angle (o_out.heading_angle)
);

[tb/sv/imu_bias_filter_heading_top_tb.sv]
`timescale 1ns / 100ps

// Self-checking bench for the IMU bias / filter / heading block.
// A short directed table runs first, then phases of random traffic, each
// under its own register settings. An in-bench estimator tracks calibration
// sums, biases, filter state and heading, and each o_out transaction is
// compared with the oldest queued reading.
module imu_bias_filter_heading_top_tb;
    import ibf_pkg::*;

    localparam int   CAL_LOG2_CAP = 12;
    localparam logic OP_CALIB     = 1'b0;
    localparam logic OP_MEASURE   = 1'b1;

    // one reading as it leaves the block
    typedef struct packed {
        logic                     is_calibrated;
        t_filt                    accel_x;
        t_filt                    accel_y;
        t_filt                    accel_z;
        logic signed [HEAD_W-1:0] heading;
    } t_reading;

    // a directed row: either a full set of register writes or one sample,
    // the latter optionally with a hand-written reading
    typedef struct {
        logic                 is_cfg;
        logic [LOG2_W-1:0]    log2;
        logic [AGAIN_W-1:0]   gain;
        logic [ALPHA_W-1:0]   alpha;
        logic [GGAIN_W-1:0]   ggain;
        t_item                sample;
        logic                 typed;
        t_reading             want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    ibf_in_if  in_if ();
    ibf_out_if out_if ();
    ibf_cfg_if cfg_if ();

    imu_bias_filter_heading_top #(
        .MAX_CAL_LOG2(CAL_LOG2_CAP)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // ---------------------------------------------------------------------
    // Estimator state and register copies
    // ---------------------------------------------------------------------
    logic [LOG2_W-1:0]  set_log2       = RST_CALIB_LOG2;
    logic [AGAIN_W-1:0] set_accel_gain = RST_ACCEL_GAIN;
    logic [ALPHA_W-1:0] set_alpha      = RST_FILTER_ALPHA;
    logic [GGAIN_W-1:0] set_gyro_gain  = RST_GYRO_GAIN;

    int unsigned  cal_tally   = 0;
    longint       accel_sum [3] = '{0, 0, 0};
    longint       rate_sum    = 0;
    longint       accel_bias [3] = '{0, 0, 0};
    longint       rate_bias   = 0;
    longint       accel_lp [3] = '{0, 0, 0};
    logic [31:0]  heading_est = '0;
    logic [31:0]  last_stamp  = '0;
    logic         calibrated  = 1'b0;

    t_reading     expected_readings [$];
    t_row         directed_rows [$];
    int unsigned  mismatch_count = 0;
    logic         gaps_on = 1'b1;
    logic [31:0]  sample_clock = '0;

    // Advance the estimator by one accepted sample and return the reading
    // the block should report for it.
    function automatic t_reading predict_sample(t_item s);
        longint      raw [4];
        longint      alpha;
        longint      diff;
        longint      scaled;
        longint      mixed;
        longint      rate;
        int          k;
        logic [31:0] dt;
        logic [63:0] prod;
        t_reading    r;
        raw[0] = longint'(s.accel_x_raw);
        raw[1] = longint'(s.accel_y_raw);
        raw[2] = longint'(s.accel_z_raw);
        raw[3] = longint'(s.gyro_z_raw);
        if (s.operation == OP_CALIB) begin
            // oversized log2 is held at the cap
            k = (set_log2 > CAL_LOG2_CAP) ? CAL_LOG2_CAP : int'(set_log2);
            for (int i = 0; i < 3; i++) accel_sum[i] += raw[i];
            rate_sum += raw[3];
            cal_tally++;
            // >= so that a count lowered mid-run completes at once
            if (cal_tally >= (1 << k)) begin
                for (int i = 0; i < 3; i++) begin
                    accel_bias[i] = (accel_sum[i] <<< FRAC_W) >>> k;
                    accel_sum[i]  = 0;
                end
                rate_bias   = (rate_sum <<< FRAC_W) >>> k;
                rate_sum    = 0;
                cal_tally   = 0;
                calibrated  = 1'b1;
                heading_est = '0;
                last_stamp  = s.time_ms;
            end
        end else if (calibrated) begin
            alpha = (set_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(set_alpha);
            for (int i = 0; i < 3; i++) begin
                diff   = (raw[i] <<< FRAC_W) - accel_bias[i];
                scaled = (diff * longint'(set_accel_gain)) >>> SCALE_SH;
                mixed  = (alpha * scaled + (longint'(ALPHA_ONE) - alpha) * accel_lp[i])
                         >>> SCALE_SH;
                if (mixed > longint'(FILT_MAX)) mixed = longint'(FILT_MAX);
                if (mixed < longint'(FILT_MIN)) mixed = longint'(FILT_MIN);
                accel_lp[i] = mixed;
            end
            rate       = (raw[3] <<< FRAC_W) - rate_bias;
            dt         = s.time_ms - last_stamp;
            last_stamp = s.time_ms;
            // only product bits 24..55 reach the heading, so mod 2^64 is enough
            prod = 64'(rate) * 64'(set_gyro_gain) * 64'(dt);
            heading_est += prod[GYRO_MOD_W-1:GYRO_SH];
        end
        r.is_calibrated = calibrated;
        r.accel_x       = t_filt'(accel_lp[0]);
        r.accel_y       = t_filt'(accel_lp[1]);
        r.accel_z       = t_filt'(accel_lp[2]);
        r.heading       = heading_est;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Directed table helpers
    // ---------------------------------------------------------------------
    function automatic void add_cfg(logic [LOG2_W-1:0] log2, logic [AGAIN_W-1:0] gain,
                                    logic [ALPHA_W-1:0] alpha, logic [GGAIN_W-1:0] ggain);
        t_row row;
        row.is_cfg = 1'b1;
        row.log2   = log2;
        row.gain   = gain;
        row.alpha  = alpha;
        row.ggain  = ggain;
        row.sample = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_row(logic op, t_raw x, t_raw y, t_raw z, t_raw g,
                                    logic [TIME_W-1:0] t, logic typed = 1'b0,
                                    t_reading want = '0);
        t_row row;
        row.is_cfg = 1'b0;
        row.log2   = '0;
        row.gain   = '0;
        row.alpha  = '0;
        row.ggain  = '0;
        row.sample = '{op, x, y, z, g, t};
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endfunction

    // ---------------------------------------------------------------------
    // Random content
    // ---------------------------------------------------------------------
    function automatic t_raw random_count();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return t_raw'($urandom_range(0, 31) - 16);
            default: return t_raw'($urandom());
        endcase
    endfunction

    function automatic t_item random_sample(logic op);
        t_item s;
        // mostly short steps, now and then a long jump or a wrap
        case ($urandom_range(0, 9))
            0:       sample_clock = $urandom();
            1:       sample_clock += $urandom_range(0, 1 << 20);
            default: sample_clock += $urandom_range(0, 40);
        endcase
        s.operation   = op;
        s.accel_x_raw = random_count();
        s.accel_y_raw = random_count();
        s.accel_z_raw = random_count();
        s.gyro_z_raw  = random_count();
        s.time_ms     = sample_clock;
        return s;
    endfunction

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------
    // Valid is left high after a transaction; it only drops on an idle
    // cycle or when draining, so it is never lowered and raised in one step.
    task automatic send_sample(t_item s, logic typed = 1'b0, t_reading want = '0);
        t_reading model;
        while (gaps_on && $urandom_range(0, 99) < 27) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.operation   <= s.operation;
        in_if.accel_x_raw <= s.accel_x_raw;
        in_if.accel_y_raw <= s.accel_y_raw;
        in_if.accel_z_raw <= s.accel_z_raw;
        in_if.gyro_z_raw  <= s.gyro_z_raw;
        in_if.time_ms     <= s.time_ms;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        model = predict_sample(s);
        expected_readings.push_back(typed ? want : model);
    endtask

    // Hold off the sender until every outstanding reading has come back.
    task automatic drain_readings();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_readings.size() != 0);
    endtask

    // Rewrite all four registers while the block is idle.
    task automatic apply_settings(logic [LOG2_W-1:0] log2, logic [AGAIN_W-1:0] gain,
                                  logic [ALPHA_W-1:0] alpha, logic [GGAIN_W-1:0] ggain);
        t_cfg_idx              order [4];
        logic [CFG_DATA_W-1:0] vals [4];
        order = '{CFG_CALIB_LOG2, CFG_ACCEL_GAIN, CFG_FILTER_ALPHA, CFG_GYRO_GAIN};
        vals  = '{CFG_DATA_W'(log2), CFG_DATA_W'(gain), CFG_DATA_W'(alpha),
                  CFG_DATA_W'(ggain)};
        drain_readings();
        for (int i = 0; i < 4; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= order[i];
            cfg_if.data  <= vals[i];
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
        end
        cfg_if.valid   <= 1'b0;
        set_log2       = log2;
        set_accel_gain = gain;
        set_alpha      = alpha;
        set_gyro_gain  = ggain;
    endtask

    // ---------------------------------------------------------------------
    // Receiver side: check each o_out transaction, then pick next ready
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.is_calibrated, out_if.accel_x_filt, out_if.accel_y_filt,
                    out_if.accel_z_filt, out_if.heading_angle};
            if (expected_readings.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: reading with none outstanding: cal=%0b x=%0d y=%0d z=%0d h=%0d",
                             $realtime, got.is_calibrated, got.accel_x, got.accel_y,
                             got.accel_z, got.heading);
                mismatch_count++;
            end else begin
                want = expected_readings.pop_front();
                if (got.is_calibrated !== want.is_calibrated || got.accel_x !== want.accel_x ||
                    got.accel_y !== want.accel_y || got.accel_z !== want.accel_z ||
                    got.heading !== want.heading) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: reading mismatch", $realtime);
                        $display("  exp cal=%0b x=%0d y=%0d z=%0d h=%0d", want.is_calibrated,
                                 want.accel_x, want.accel_y, want.accel_z, want.heading);
                        $display("  got cal=%0b x=%0d y=%0d z=%0d h=%0d", got.is_calibrated,
                                 got.accel_x, got.accel_y, got.accel_z, got.heading);
                    end
                    mismatch_count++;
                end
            end
        end
        out_if.ready <= !gaps_on || ($urandom_range(0, 99) >= 27);
    end

    // ---------------------------------------------------------------------
    // Clock and run limit
    // ---------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin
        logic [LOG2_W-1:0]  log2;
        logic [AGAIN_W-1:0] gain;
        logic [ALPHA_W-1:0] alpha;
        logic [GGAIN_W-1:0] ggain;

        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.operation   <= OP_CALIB;
        in_if.accel_x_raw <= '0;
        in_if.accel_y_raw <= '0;
        in_if.accel_z_raw <= '0;
        in_if.gyro_z_raw  <= '0;
        in_if.time_ms     <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= CFG_CALIB_LOG2;
        cfg_if.data       <= '0;
        out_if.ready      <= 1'b0;

        // Directed table. Typed readings are the obvious ones: reset state,
        // first calibration on zeros, and saturated filters.
        // measurement before calibration leaves everything at zero
        add_row(OP_MEASURE, 16'sh8000, 16'sh7FFF, -16'sd1, 16'sh7FFF, 32'd500,
                1'b1, '0);
        // one sample of 512 counted, still uncalibrated
        add_row(OP_CALIB, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd600, 1'b1, '0);
        // count lowered below what is already summed: next sample completes;
        // full gain and unit alpha so one full-scale sample drives a filter to its rail
        add_cfg(4'd0, 16'hFFFF, ALPHA_ONE, 24'd0);
        add_row(OP_CALIB, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd1000,
                1'b1, '{1'b1, t_filt'(0), t_filt'(0), t_filt'(0), 32'sd0});
        add_row(OP_MEASURE, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sh7FFF, 32'd1010,
                1'b1, '{1'b1, FILT_MAX, FILT_MIN, t_filt'(0), 32'sd0});
        // alpha above one is held at one; full gyro gain
        add_cfg(4'd0, 16'hFFFF, 17'h1FFFF, 24'hFFFFFF);
        add_row(OP_MEASURE, 16'sh8000, 16'sh7FFF, 16'sd1, 16'sd0, 32'd1020,
                1'b1, '{1'b1, FILT_MIN, FILT_MAX, t_filt'(255), 32'sd0});
        add_row(OP_MEASURE, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 32'd1021);
        add_row(OP_MEASURE, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 32'hFFFF_FFF0);
        // timestamp wraps
        add_row(OP_MEASURE, 16'sd5, -16'sd5, 16'sd0, 16'sh8000, 32'h0000_0010);
        // zero alpha freezes the filters
        add_cfg(4'd3, 16'd1, 17'd0, RST_GYRO_GAIN);
        add_row(OP_MEASURE, 16'sd1000, 16'sd1000, 16'sd1000, 16'sd100, 32'h0000_0020);
        // recalibration, cut short by lowering the count after five samples
        add_row(OP_CALIB, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'h0000_0030);
        add_row(OP_CALIB, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 32'h0000_0031);
        add_row(OP_CALIB, 16'sd1234, -16'sd4321, 16'sd16384, -16'sd200, 32'h0000_0032);
        add_row(OP_CALIB, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0033);
        add_row(OP_CALIB, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 32'h0000_0034);
        add_cfg(4'd2, 16'd1024, 17'd40000, RST_GYRO_GAIN);
        add_row(OP_CALIB, 16'sd7, -16'sd9, 16'sd300, 16'sd55, 32'h0000_0040);
        add_row(OP_MEASURE, 16'sd900, -16'sd700, 16'sd4000, 16'sd300, 32'h0000_0050);
        add_row(OP_MEASURE, -16'sd900, 16'sd700, 16'sd4100, -16'sd300, 32'h0000_0075);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].is_cfg) begin
                apply_settings(directed_rows[n].log2, directed_rows[n].gain,
                               directed_rows[n].alpha, directed_rows[n].ggain);
            end else begin
                send_sample(directed_rows[n].sample, directed_rows[n].typed,
                            directed_rows[n].want);
            end
        end
        sample_clock = 32'h0000_0100;

        // Random phases: a full calibration run under fresh settings, then
        // measurements with stray calibration samples mixed in. Phase 3 runs
        // without any idling on either side.
        for (int ph = 0; ph < 8; ph++) begin
            log2 = (ph == 2) ? 4'd6 : 4'($urandom_range(0, 4));
            case ($urandom_range(0, 3))
                0:       gain = 16'd1;
                1:       gain = 16'hFFFF;
                default: gain = 16'($urandom_range(1, 65535));
            endcase
            case (ph)
                1:       alpha = '0;
                5:       alpha = ALPHA_ONE;
                6:       alpha = 17'($urandom_range(65537, 131071));
                default: alpha = 17'($urandom_range(0, 65536));
            endcase
            case (ph)
                4:       ggain = 24'hFFFFFF;
                7:       ggain = '0;
                default: ggain = 24'($urandom());
            endcase
            apply_settings(log2, gain, alpha, ggain);
            gaps_on = (ph != 3);
            repeat (1 << log2) send_sample(random_sample(OP_CALIB));
            for (int n = 0; n < 70; n++) begin
                // sender holds off mid-phase until the pipe is empty
                if (ph == 0 && n == 35) drain_readings();
                send_sample(random_sample(($urandom_range(0, 99) < 12) ? OP_CALIB
                                                                       : OP_MEASURE));
            end
        end
        gaps_on = 1'b1;

        // log2 above the cap is held at 4096 samples, so a short run must not
        // complete; lowering the count afterwards completes at the next sample
        apply_settings(4'($urandom_range(13, 15)), RST_ACCEL_GAIN, RST_FILTER_ALPHA,
                       RST_GYRO_GAIN);
        repeat (40) send_sample(random_sample(OP_CALIB));
        repeat (12) send_sample(random_sample(OP_MEASURE));
        apply_settings(4'd5, RST_ACCEL_GAIN, RST_FILTER_ALPHA, RST_GYRO_GAIN);
        repeat (2) send_sample(random_sample(OP_CALIB));
        repeat (12) send_sample(random_sample(OP_MEASURE));

        drain_readings();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
design/ibf_pkg.sv
design/ibf_in_if.sv
design/ibf_out_if.sv
design/ibf_cfg_if.sv
design/ibf_accel_lane.sv
design/ibf_gyro_lane.sv
design/imu_bias_filter_heading_top.sv
design/ibf_chk.sv
tb/sv/imu_bias_filter_heading_top_tb.sv
